/* sv/plcm_pkg.sv */
// Shared types and constants of the pooled cursor list manager.
// No dependencies; every other file refers to it by scoped names.
package plcm_pkg;

	// List handles are 4 bits wide, so the handle table has one entry per code.
	localparam int HW = 4;
	localparam int NUM_LISTS = 1 << HW;

	localparam int DEF_NUM_NODES = 256;
	localparam int DEF_ITEM_WIDTH = 32;

	// Fixed payload widths of the channels.
	localparam int ACT_W = 4;
	localparam int VAL_W = 32;
	localparam int ST_W = 2;
	localparam int CNT_W = 9;

	typedef enum logic [ACT_W-1:0] {
		ACT_CREATE = 4'd0,
		ACT_COUNT = 4'd1,
		ACT_FIRST = 4'd2,
		ACT_LAST = 4'd3,
		ACT_NEXT = 4'd4,
		ACT_PREV = 4'd5,
		ACT_CURRENT = 4'd6,
		ACT_INS_AFTER = 4'd7,
		ACT_INS_BEFORE = 4'd8,
		ACT_APPEND = 4'd9,
		ACT_PREPEND = 4'd10,
		ACT_REMOVE = 4'd11,
		ACT_TRIM = 4'd12,
		ACT_CONCAT = 4'd13,
		ACT_FREE = 4'd14,
		ACT_SEARCH = 4'd15
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_ITEM = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2,
		ST_BADH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PL_ON = 2'd0,
		PL_BEFORE = 2'd1,
		PL_BEYOND = 2'd2
	} place_t;

	// Field write enables of the node memory.
	typedef struct packed {
		logic item;
		logic prev;
		logic next;
	} node_we_t;

	// Requests to the free node pool.
	typedef struct packed {
		logic pop;
		logic push;
	} pool_cmd_t;

	// Fill state of the free node pool.
	typedef struct packed {
		logic empty;
		logic full;
	} pool_stat_t;

endpackage

/* sv/plcm_if.sv */
// Command and response channel interfaces of the pooled cursor list manager.
// Depends on plcm_pkg for the payload widths.
interface plcm_cmd_if;
	logic valid;
	logic ready;
	logic [plcm_pkg::ACT_W-1:0] action;
	logic [plcm_pkg::HW-1:0] list_sel;
	logic [plcm_pkg::HW-1:0] second_list;
	logic [plcm_pkg::VAL_W-1:0] item_value;

	modport source (output valid, action, list_sel, second_list, item_value, input ready);
	modport sink (input valid, action, list_sel, second_list, item_value, output ready);
endinterface

interface plcm_rsp_if;
	logic valid;
	logic ready;
	logic [plcm_pkg::ST_W-1:0] status;
	logic [plcm_pkg::VAL_W-1:0] item_result;
	logic [plcm_pkg::HW-1:0] new_handle;
	logic [plcm_pkg::CNT_W-1:0] item_count;

	modport source (output valid, status, item_result, new_handle, item_count, input ready);
	modport sink (input valid, status, item_result, new_handle, item_count, output ready);
endinterface

/* sv/plcm_node_mem.sv */
// Node memory: next link, prev link and item of every pool node.
// One write port with field enables, one read port with registered data.
module plcm_node_mem #(
	parameter int NUM_NODES = plcm_pkg::DEF_NUM_NODES,
	parameter int ITEM_WIDTH = plcm_pkg::DEF_ITEM_WIDTH,
	localparam int AW = $clog2(NUM_NODES),
	localparam int PW = $clog2(NUM_NODES + 1)
) (
	input  logic clk,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	input  plcm_pkg::node_we_t we,
	input  logic [AW-1:0] wr_addr,
	input  logic [PW-1:0] wr_next,
	input  logic [PW-1:0] wr_prev,
	input  logic [ITEM_WIDTH-1:0] wr_item,
	output logic [PW-1:0] rd_next,
	output logic [PW-1:0] rd_prev,
	output logic [ITEM_WIDTH-1:0] rd_item
);

	logic [PW-1:0] next_mem [NUM_NODES];
	logic [PW-1:0] prev_mem [NUM_NODES];
	logic [ITEM_WIDTH-1:0] item_mem [NUM_NODES];

	always_ff @(posedge clk) begin
		if (we.next) begin
			next_mem[wr_addr] <= wr_next;
		end
		if (we.prev) begin
			prev_mem[wr_addr] <= wr_prev;
		end
		if (we.item) begin
			item_mem[wr_addr] <= wr_item;
		end
		if (rd_en) begin
			rd_next <= next_mem[rd_addr];
			rd_prev <= prev_mem[rd_addr];
			rd_item <= item_mem[rd_addr];
		end
	end

endmodule

/* sv/plcm_free_pool.sv */
// Free node pool: LIFO stack of node indexes in a memory with registered reads.
// Depends on plcm_pkg; entries below the low-water mark read as their own index.
module plcm_free_pool #(
	parameter int NUM_NODES = plcm_pkg::DEF_NUM_NODES,
	localparam int AW = $clog2(NUM_NODES),
	localparam int PW = $clog2(NUM_NODES + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  plcm_pkg::pool_cmd_t cmd,
	input  logic [AW-1:0] push_node,
	output logic [AW-1:0] pop_node,
	output plcm_pkg::pool_stat_t stat
);

	logic [AW-1:0] mem [NUM_NODES];
	logic [PW-1:0] top_q;
	logic [PW-1:0] low_q;
	logic [PW-1:0] top_dec;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] idx_q;
	logic fresh_q;

	assign top_dec = top_q - PW'(1);
	assign stat.empty = (top_q == '0);
	assign stat.full = (top_q == PW'(NUM_NODES));

	// A slot never reached by a push since reset reads as its own index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= PW'(NUM_NODES);
			low_q <= PW'(NUM_NODES);
		end else if (cmd.pop) begin
			top_q <= top_dec;
			if (top_dec < low_q) begin
				low_q <= top_dec;
			end
		end else if (cmd.push) begin
			top_q <= top_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[top_q[AW-1:0]] <= push_node;
		end
		if (cmd.pop) begin
			rd_q <= mem[top_dec[AW-1:0]];
			idx_q <= top_dec[AW-1:0];
			fresh_q <= (top_dec < low_q);
		end
	end

	assign pop_node = fresh_q ? idx_q : rd_q;

endmodule

/* sv/pooled_cursor_list_manager.sv */
// Top level of the pooled cursor list manager: handle table, command sequencer, response register.
// Depends on plcm_pkg, plcm_if, plcm_node_mem and plcm_free_pool.
//
// Sixteen doubly linked lists share one pool of NUM_NODES nodes; each list keeps a cursor that
// is on an item, before the start or beyond the end. One command item gives exactly one
// response item. Commands run one at a time on a sequencer around the node memory, whose read
// data arrives in the cycle after the address, so the cost is set by the memory accesses. Create,
// count, bad handle, a failed node pop and every command that finds nothing to do at once go
// straight from execute to commit; first, last and current with an item read that item; next
// and prev read the cursor node and then, when they land on an item, that item; insert, append
// and prepend write the new node and then up to two links; remove reads its node and writes up
// to two links, trim reads the last node and writes up to one; concat writes up to two links.
// Free reads and returns each node of the list in turn; search reads each node visited until a
// match. The command channel is ready again in the cycle after the response is loaded, and the
// next command is taken while a response still waits in the output register; a response that
// is not taken holds the following command in its commit state. No clearing pass follows reset.
module pooled_cursor_list_manager #(
	parameter int NUM_NODES = plcm_pkg::DEF_NUM_NODES,
	parameter int ITEM_WIDTH = plcm_pkg::DEF_ITEM_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	plcm_cmd_if.sink cmd,
	plcm_rsp_if.source rsp
);

	localparam int AW = $clog2(NUM_NODES);
	localparam int PW = $clog2(NUM_NODES + 1);
	localparam int HW = plcm_pkg::HW;
	localparam int NL = plcm_pkg::NUM_LISTS;
	localparam logic [PW-1:0] NIL = PW'(NUM_NODES);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_EXEC = 13'b0000000000010,
		S_ITEM = 13'b0000000000100,
		S_NAV = 13'b0000000001000,
		S_INS = 13'b0000000010000,
		S_LINK1 = 13'b0000000100000,
		S_LINK2 = 13'b0000001000000,
		S_RM = 13'b0000010000000,
		S_TRIM = 13'b0000100000000,
		S_WALK = 13'b0001000000000,
		S_FREE = 13'b0010000000000,
		S_SRCH = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		INS_APP = 2'd0,
		INS_PRE = 2'd1,
		INS_AFT = 2'd2,
		INS_BEF = 2'd3
	} ins_t;

	function automatic logic vld(input logic [PW-1:0] p);
		return p < NIL;
	endfunction

	// Handle table: in-use bits reset, entries are set up by create before any use.
	logic [NL-1:0] in_use_q;
	logic [PW-1:0] tbl_first [NL];
	logic [PW-1:0] tbl_last [NL];
	logic [PW-1:0] tbl_cur [NL];
	logic [PW-1:0] tbl_size [NL];
	plcm_pkg::place_t tbl_place [NL];

	logic [HW-1:0] tbl_ridx;
	logic tbl_we;
	logic [HW-1:0] tbl_widx;
	logic [PW-1:0] tbl_wfirst, tbl_wlast, tbl_wcur, tbl_wsize;
	plcm_pkg::place_t tbl_wplace;
	logic iu_we, iu_val;
	logic [HW-1:0] iu_idx;

	// Sequencer state and working copy of the addressed list.
	state_t state_q, state_d;
	plcm_pkg::action_t act_q, act_d;
	logic [HW-1:0] h_q, h_d, h2_q, h2_d;
	logic [ITEM_WIDTH-1:0] val_q, val_d;
	logic [PW-1:0] first_q, first_d, last_q, last_d, cur_q, cur_d, size_q, size_d;
	plcm_pkg::place_t place_q, place_d;
	logic [PW-1:0] n_q, n_d, guard_q, guard_d;
	ins_t mode_q, mode_d;
	logic lk1_en_q, lk1_en_d, lk1_prev_q, lk1_prev_d;
	logic [PW-1:0] lk1_addr_q, lk1_addr_d, lk1_data_q, lk1_data_d;
	logic lk2_en_q, lk2_en_d, lk2_prev_q, lk2_prev_d;
	logic [PW-1:0] lk2_addr_q, lk2_addr_d, lk2_data_q, lk2_data_d;
	logic wb_q, wb_d, iu_we_q, iu_we_d, iu_val_q, iu_val_d;
	plcm_pkg::status_t rs_status_q, rs_status_d;
	logic [ITEM_WIDTH-1:0] rs_item_q, rs_item_d;
	logic [HW-1:0] rs_handle_q, rs_handle_d;
	logic [PW-1:0] rs_count_q, rs_count_d;

	// Response register.
	logic out_valid_q, out_valid_d, out_load;
	plcm_pkg::status_t o_status_q;
	logic [plcm_pkg::VAL_W-1:0] o_item_q;
	logic [HW-1:0] o_handle_q;
	logic [plcm_pkg::CNT_W-1:0] o_count_q;

	// Node memory and free pool ports.
	logic mem_rd_en;
	logic [AW-1:0] mem_rd_addr, mem_wr_addr;
	plcm_pkg::node_we_t mem_we;
	logic [PW-1:0] mem_wr_next, mem_wr_prev, rd_next, rd_prev;
	logic [ITEM_WIDTH-1:0] mem_wr_item, rd_item;
	plcm_pkg::pool_cmd_t pool_cmd;
	plcm_pkg::pool_stat_t pool_stat;
	logic [AW-1:0] pool_push_node, pool_pop_node;

	logic free_found;
	logic [HW-1:0] free_idx;
	logic on_item;
	logic [PW-1:0] nn, pick;

	plcm_node_mem #(
		.NUM_NODES(NUM_NODES),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_node_mem (
		.clk(clk),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.we(mem_we),
		.wr_addr(mem_wr_addr),
		.wr_next(mem_wr_next),
		.wr_prev(mem_wr_prev),
		.wr_item(mem_wr_item),
		.rd_next(rd_next),
		.rd_prev(rd_prev),
		.rd_item(rd_item)
	);

	plcm_free_pool #(
		.NUM_NODES(NUM_NODES)
	) u_free_pool (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pool_cmd),
		.push_node(pool_push_node),
		.pop_node(pool_pop_node),
		.stat(pool_stat)
	);

	// Lowest handle not in use, for create.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NL - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx = HW'(i);
			end
		end
	end

	// One table read port: the addressed list at accept, the second list of a concat later.
	assign tbl_ridx = (state_q == S_IDLE) ? cmd.list_sel : h2_q;
	assign on_item = (place_q == plcm_pkg::PL_ON) && vld(cur_q);
	assign nn = PW'(pool_pop_node);
	assign cmd.ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		act_d = act_q;
		h_d = h_q;
		h2_d = h2_q;
		val_d = val_q;
		first_d = first_q;
		last_d = last_q;
		cur_d = cur_q;
		size_d = size_q;
		place_d = place_q;
		n_d = n_q;
		guard_d = guard_q;
		mode_d = mode_q;
		lk1_en_d = lk1_en_q;
		lk1_prev_d = lk1_prev_q;
		lk1_addr_d = lk1_addr_q;
		lk1_data_d = lk1_data_q;
		lk2_en_d = lk2_en_q;
		lk2_prev_d = lk2_prev_q;
		lk2_addr_d = lk2_addr_q;
		lk2_data_d = lk2_data_q;
		wb_d = wb_q;
		iu_we_d = iu_we_q;
		iu_val_d = iu_val_q;
		rs_status_d = rs_status_q;
		rs_item_d = rs_item_q;
		rs_handle_d = rs_handle_q;
		rs_count_d = rs_count_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_load = 1'b0;

		mem_rd_en = 1'b0;
		mem_rd_addr = '0;
		mem_we = '0;
		mem_wr_addr = '0;
		mem_wr_next = '0;
		mem_wr_prev = '0;
		mem_wr_item = val_q;
		pool_cmd = '0;
		pool_push_node = '0;

		tbl_we = 1'b0;
		tbl_widx = h_q;
		tbl_wfirst = first_q;
		tbl_wlast = last_q;
		tbl_wcur = cur_q;
		tbl_wsize = size_q;
		tbl_wplace = place_q;
		iu_we = 1'b0;
		iu_idx = h_q;
		iu_val = iu_val_q;
		pick = '0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					act_d = plcm_pkg::action_t'(cmd.action);
					h_d = cmd.list_sel;
					h2_d = cmd.second_list;
					val_d = ITEM_WIDTH'(cmd.item_value);
					first_d = tbl_first[tbl_ridx];
					last_d = tbl_last[tbl_ridx];
					cur_d = tbl_cur[tbl_ridx];
					size_d = tbl_size[tbl_ridx];
					place_d = tbl_place[tbl_ridx];
					guard_d = '0;
					lk1_en_d = 1'b0;
					lk2_en_d = 1'b0;
					wb_d = 1'b0;
					iu_we_d = 1'b0;
					rs_status_d = plcm_pkg::ST_NONE;
					rs_item_d = '0;
					rs_handle_d = '0;
					rs_count_d = '0;
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				state_d = S_DONE;
				if (act_q == plcm_pkg::ACT_CREATE) begin
					if (free_found) begin
						h_d = free_idx;
						first_d = NIL;
						last_d = NIL;
						cur_d = NIL;
						size_d = '0;
						place_d = plcm_pkg::PL_BEYOND;
						wb_d = 1'b1;
						iu_we_d = 1'b1;
						iu_val_d = 1'b1;
						rs_handle_d = free_idx;
					end else begin
						rs_status_d = plcm_pkg::ST_FULL;
					end
				end else if (!in_use_q[h_q]) begin
					rs_status_d = plcm_pkg::ST_BADH;
				end else begin
					unique case (act_q)
						plcm_pkg::ACT_COUNT: begin
							rs_count_d = size_q;
						end
						plcm_pkg::ACT_FIRST, plcm_pkg::ACT_LAST: begin
							pick = (act_q == plcm_pkg::ACT_FIRST) ? first_q : last_q;
							wb_d = 1'b1;
							if (vld(pick)) begin
								cur_d = pick;
								place_d = plcm_pkg::PL_ON;
								mem_rd_en = 1'b1;
								mem_rd_addr = pick[AW-1:0];
								state_d = S_ITEM;
							end else begin
								cur_d = NIL;
								place_d = plcm_pkg::PL_BEYOND;
							end
						end
						plcm_pkg::ACT_NEXT, plcm_pkg::ACT_PREV, plcm_pkg::ACT_CURRENT: begin
							if (on_item) begin
								mem_rd_en = 1'b1;
								mem_rd_addr = cur_q[AW-1:0];
								state_d = (act_q == plcm_pkg::ACT_CURRENT) ? S_ITEM : S_NAV;
							end
						end
						plcm_pkg::ACT_INS_AFTER, plcm_pkg::ACT_INS_BEFORE,
						plcm_pkg::ACT_APPEND, plcm_pkg::ACT_PREPEND: begin
							// Insert with the cursor off the list falls back to prepend or append.
							if (act_q == plcm_pkg::ACT_APPEND) begin
								mode_d = INS_APP;
							end else if (act_q == plcm_pkg::ACT_PREPEND) begin
								mode_d = INS_PRE;
							end else if (place_q == plcm_pkg::PL_BEFORE) begin
								mode_d = INS_PRE;
							end else if (!on_item) begin
								mode_d = INS_APP;
							end else if (act_q == plcm_pkg::ACT_INS_AFTER) begin
								mode_d = INS_AFT;
							end else begin
								mode_d = INS_BEF;
							end
							if (pool_stat.empty) begin
								rs_status_d = plcm_pkg::ST_FULL;
							end else begin
								pool_cmd.pop = 1'b1;
								mem_rd_en = 1'b1;
								mem_rd_addr = cur_q[AW-1:0];
								state_d = S_INS;
							end
						end
						plcm_pkg::ACT_REMOVE: begin
							if (on_item) begin
								mem_rd_en = 1'b1;
								mem_rd_addr = cur_q[AW-1:0];
								state_d = S_RM;
							end
						end
						plcm_pkg::ACT_TRIM: begin
							if (vld(last_q)) begin
								mem_rd_en = 1'b1;
								mem_rd_addr = last_q[AW-1:0];
								state_d = S_TRIM;
							end
						end
						plcm_pkg::ACT_CONCAT: begin
							if (!in_use_q[h2_q] || (h2_q == h_q)) begin
								rs_status_d = plcm_pkg::ST_BADH;
							end else begin
								if (vld(tbl_first[tbl_ridx])) begin
									wb_d = 1'b1;
									if (!vld(first_q)) begin
										first_d = tbl_first[tbl_ridx];
										last_d = tbl_last[tbl_ridx];
										size_d = tbl_size[tbl_ridx];
										cur_d = NIL;
										place_d = plcm_pkg::PL_BEFORE;
									end else begin
										// Splice: tail of the first list to head of the second.
										lk1_en_d = vld(last_q);
										lk1_prev_d = 1'b0;
										lk1_addr_d = last_q;
										lk1_data_d = tbl_first[tbl_ridx];
										lk2_en_d = 1'b1;
										lk2_prev_d = 1'b1;
										lk2_addr_d = tbl_first[tbl_ridx];
										lk2_data_d = last_q;
										last_d = tbl_last[tbl_ridx];
										size_d = size_q + tbl_size[tbl_ridx];
									end
								end
								// Release the second handle now.
								tbl_we = 1'b1;
								tbl_widx = h2_q;
								tbl_wfirst = NIL;
								tbl_wlast = NIL;
								tbl_wcur = NIL;
								tbl_wsize = '0;
								tbl_wplace = plcm_pkg::PL_BEYOND;
								iu_we = 1'b1;
								iu_idx = h2_q;
								iu_val = 1'b0;
								state_d = S_LINK1;
							end
						end
						plcm_pkg::ACT_FREE: begin
							n_d = first_q;
							state_d = S_WALK;
						end
						plcm_pkg::ACT_SEARCH: begin
							// Search from before the start begins at the head.
							if (place_q != plcm_pkg::PL_BEYOND) begin
								n_d = (place_q == plcm_pkg::PL_BEFORE) ? first_q : cur_q;
								state_d = S_WALK;
							end
						end
						default: begin
							rs_status_d = plcm_pkg::ST_NONE;
						end
					endcase
				end
			end

			S_ITEM: begin
				rs_status_d = plcm_pkg::ST_ITEM;
				rs_item_d = rd_item;
				state_d = S_DONE;
			end

			S_NAV: begin
				pick = (act_q == plcm_pkg::ACT_NEXT) ? rd_next : rd_prev;
				wb_d = 1'b1;
				if (vld(pick)) begin
					cur_d = pick;
					mem_rd_en = 1'b1;
					mem_rd_addr = pick[AW-1:0];
					state_d = S_ITEM;
				end else begin
					cur_d = NIL;
					place_d = (act_q == plcm_pkg::ACT_NEXT) ? plcm_pkg::PL_BEYOND
						: plcm_pkg::PL_BEFORE;
					state_d = S_DONE;
				end
			end

			S_INS: begin
				// Write the new node whole, then patch its neighbors in the link states.
				mem_we = '{item: 1'b1, prev: 1'b1, next: 1'b1};
				mem_wr_addr = pool_pop_node;
				mem_wr_item = val_q;
				lk1_data_d = nn;
				lk2_data_d = nn;
				lk2_en_d = 1'b0;
				case (mode_q)
					INS_APP: begin
						mem_wr_next = NIL;
						mem_wr_prev = last_q;
						lk1_en_d = vld(last_q);
						lk1_prev_d = 1'b0;
						lk1_addr_d = last_q;
						if (!vld(last_q)) begin
							first_d = nn;
						end
						last_d = nn;
					end
					INS_PRE: begin
						mem_wr_prev = NIL;
						mem_wr_next = first_q;
						lk1_en_d = vld(first_q);
						lk1_prev_d = 1'b1;
						lk1_addr_d = first_q;
						if (!vld(first_q)) begin
							last_d = nn;
						end
						first_d = nn;
					end
					INS_AFT: begin
						mem_wr_prev = cur_q;
						mem_wr_next = rd_next;
						lk1_en_d = vld(rd_next);
						lk1_prev_d = 1'b1;
						lk1_addr_d = rd_next;
						if (!vld(rd_next)) begin
							last_d = nn;
						end
						lk2_en_d = 1'b1;
						lk2_prev_d = 1'b0;
						lk2_addr_d = cur_q;
					end
					default: begin
						mem_wr_next = cur_q;
						mem_wr_prev = rd_prev;
						lk1_en_d = vld(rd_prev);
						lk1_prev_d = 1'b0;
						lk1_addr_d = rd_prev;
						if (!vld(rd_prev)) begin
							first_d = nn;
						end
						lk2_en_d = 1'b1;
						lk2_prev_d = 1'b1;
						lk2_addr_d = cur_q;
					end
				endcase
				cur_d = nn;
				place_d = plcm_pkg::PL_ON;
				size_d = size_q + PW'(1);
				wb_d = 1'b1;
				state_d = S_LINK1;
			end

			S_LINK1: begin
				mem_we.next = lk1_en_q && !lk1_prev_q;
				mem_we.prev = lk1_en_q && lk1_prev_q;
				mem_wr_addr = lk1_addr_q[AW-1:0];
				mem_wr_next = lk1_data_q;
				mem_wr_prev = lk1_data_q;
				state_d = S_LINK2;
			end

			S_LINK2: begin
				mem_we.next = lk2_en_q && !lk2_prev_q;
				mem_we.prev = lk2_en_q && lk2_prev_q;
				mem_wr_addr = lk2_addr_q[AW-1:0];
				mem_wr_next = lk2_data_q;
				mem_wr_prev = lk2_data_q;
				state_d = S_DONE;
			end

			S_RM: begin
				// Unlink the cursor node and move the cursor to its successor.
				lk1_en_d = vld(rd_prev);
				lk1_prev_d = 1'b0;
				lk1_addr_d = rd_prev;
				lk1_data_d = rd_next;
				lk2_en_d = vld(rd_next);
				lk2_prev_d = 1'b1;
				lk2_addr_d = rd_next;
				lk2_data_d = rd_prev;
				if (!vld(rd_prev)) begin
					first_d = rd_next;
				end
				if (!vld(rd_next)) begin
					last_d = rd_prev;
				end
				if (size_q != '0) begin
					size_d = size_q - PW'(1);
				end
				pool_cmd.push = !pool_stat.full;
				pool_push_node = cur_q[AW-1:0];
				if (vld(rd_next)) begin
					cur_d = rd_next;
				end else begin
					cur_d = NIL;
					place_d = plcm_pkg::PL_BEYOND;
				end
				rs_status_d = plcm_pkg::ST_ITEM;
				rs_item_d = rd_item;
				wb_d = 1'b1;
				state_d = S_LINK1;
			end

			S_TRIM: begin
				if (size_q != '0) begin
					size_d = size_q - PW'(1);
				end
				pool_cmd.push = !pool_stat.full;
				pool_push_node = last_q[AW-1:0];
				lk2_en_d = 1'b0;
				if (vld(rd_prev)) begin
					lk1_en_d = 1'b1;
					lk1_prev_d = 1'b0;
					lk1_addr_d = rd_prev;
					lk1_data_d = NIL;
					last_d = rd_prev;
					cur_d = rd_prev;
					place_d = plcm_pkg::PL_ON;
				end else begin
					lk1_en_d = 1'b0;
					first_d = NIL;
					last_d = NIL;
					cur_d = NIL;
					size_d = '0;
					place_d = plcm_pkg::PL_BEYOND;
				end
				rs_status_d = plcm_pkg::ST_ITEM;
				rs_item_d = rd_item;
				wb_d = 1'b1;
				state_d = S_LINK1;
			end

			S_WALK: begin
				if (vld(n_q) && (guard_q < NIL)) begin
					mem_rd_en = 1'b1;
					mem_rd_addr = n_q[AW-1:0];
					state_d = (act_q == plcm_pkg::ACT_FREE) ? S_FREE : S_SRCH;
				end else begin
					// End of walk: free releases the handle, search reports no match.
					wb_d = 1'b1;
					cur_d = NIL;
					place_d = plcm_pkg::PL_BEYOND;
					if (act_q == plcm_pkg::ACT_FREE) begin
						first_d = NIL;
						last_d = NIL;
						size_d = '0;
						iu_we_d = 1'b1;
						iu_val_d = 1'b0;
					end
					state_d = S_DONE;
				end
			end

			S_FREE: begin
				pool_cmd.push = !pool_stat.full;
				pool_push_node = n_q[AW-1:0];
				n_d = rd_next;
				guard_d = guard_q + PW'(1);
				state_d = S_WALK;
			end

			S_SRCH: begin
				if (rd_item == val_q) begin
					cur_d = n_q;
					place_d = plcm_pkg::PL_ON;
					wb_d = 1'b1;
					rs_status_d = plcm_pkg::ST_ITEM;
					rs_item_d = rd_item;
					state_d = S_DONE;
				end else begin
					n_d = rd_next;
					guard_d = guard_q + PW'(1);
					state_d = S_WALK;
				end
			end

			S_DONE: begin
				// Hold here until the response register is free, then commit the list.
				if (!out_valid_q || rsp.ready) begin
					tbl_we = wb_q;
					iu_we = iu_we_q;
					out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			in_use_q <= '0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
			if (iu_we) begin
				in_use_q[iu_idx] <= iu_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_first[tbl_widx] <= tbl_wfirst;
			tbl_last[tbl_widx] <= tbl_wlast;
			tbl_cur[tbl_widx] <= tbl_wcur;
			tbl_size[tbl_widx] <= tbl_wsize;
			tbl_place[tbl_widx] <= tbl_wplace;
		end
		act_q <= act_d;
		h_q <= h_d;
		h2_q <= h2_d;
		val_q <= val_d;
		first_q <= first_d;
		last_q <= last_d;
		cur_q <= cur_d;
		size_q <= size_d;
		place_q <= place_d;
		n_q <= n_d;
		guard_q <= guard_d;
		mode_q <= mode_d;
		lk1_en_q <= lk1_en_d;
		lk1_prev_q <= lk1_prev_d;
		lk1_addr_q <= lk1_addr_d;
		lk1_data_q <= lk1_data_d;
		lk2_en_q <= lk2_en_d;
		lk2_prev_q <= lk2_prev_d;
		lk2_addr_q <= lk2_addr_d;
		lk2_data_q <= lk2_data_d;
		wb_q <= wb_d;
		iu_we_q <= iu_we_d;
		iu_val_q <= iu_val_d;
		rs_status_q <= rs_status_d;
		rs_item_q <= rs_item_d;
		rs_handle_q <= rs_handle_d;
		rs_count_q <= rs_count_d;
		if (out_load) begin
			o_status_q <= rs_status_q;
			o_item_q <= plcm_pkg::VAL_W'(rs_item_q);
			o_handle_q <= rs_handle_q;
			o_count_q <= plcm_pkg::CNT_W'(rs_count_q);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = o_status_q;
	assign rsp.item_result = o_item_q;
	assign rsp.new_handle = o_handle_q;
	assign rsp.item_count = o_count_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pool_cmd.pop |-> !pool_stat.empty)
		else $error("node taken from an empty pool");

	a_push_notfull: assert property (@(posedge clk) disable iff (!arst_n)
		pool_cmd.push |-> !pool_stat.full)
		else $error("node returned to a full pool");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the commit state");
`endif

endmodule
